// ----- src/assert_macros.svh -----
// Assertion macros shared by the evaluator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pse_pkg.sv -----
// Shared widths and codes of the postfix stack evaluator.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package pse_pkg;

  localparam int unsigned ActW    = 3;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;

  localparam logic [ActW-1:0] ACT_PUSH = 3'd0;
  localparam logic [ActW-1:0] ACT_ADD  = 3'd1;
  localparam logic [ActW-1:0] ACT_SUB  = 3'd2;
  localparam logic [ActW-1:0] ACT_MUL  = 3'd3;
  localparam logic [ActW-1:0] ACT_DIV  = 3'd4;

  localparam logic [StatusW-1:0] ERR_NONE      = 2'd0;
  localparam logic [StatusW-1:0] ERR_DIVZERO   = 2'd1;
  localparam logic [StatusW-1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [StatusW-1:0] ERR_OVERFLOW  = 2'd3;

endpackage

// ----- src/pse_if.sv -----
// Token and result channel interfaces of the postfix stack evaluator.
// Depends on pse_pkg for field widths.
`timescale 1ns / 1ps

interface pse_tok_if
  import pse_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [DigitW-1:0] digit;
  logic              last;

  modport source (output valid, action, digit, last, input ready);
  modport sink   (input valid, action, digit, last, output ready);
endinterface

interface pse_res_if
  import pse_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  value;
  logic [StatusW-1:0]       status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ----- src/postfix_stack_evaluator_unit.sv -----
// Postfix evaluator: operand stack in a memory, one shared ALU and a radix-2 divider.
// A push writes the stack; add, subtract, multiply pass ST_RD and ST_WB; divide adds
// 32 divider steps (ST_DIV). The last token's result goes to the output register from
// ST_FIN once it is free. Reset (rst_ni low, asynchronous) empties the stack, clears
// the error and res_o.valid. Depends on pse_pkg, pse_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module postfix_stack_evaluator_unit
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pse_tok_if.sink        tok_i,
  pse_res_if.source      res_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [StatusW-1:0] err_q, err_d;
  logic [ActW-1:0]    act_q, act_d;
  logic               last_q, last_d;
  logic [DataW-1:0]   bot_q, bot_d;
  logic [DataW-1:0]   res_q, res_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW-1:0]   dvs_q, dvs_d;
  logic               neg_q, neg_d;
  logic [4:0]         bit_q, bit_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DataW-1:0]  out_value_q, out_value_d;
  logic [StatusW-1:0]       out_status_q, out_status_d;

  logic [DataW-1:0] mem_q [STACK_DEPTH];
  logic [DataW-1:0] rda_q, rdb_q;
  logic             rd_en;
  logic             we;
  logic [AW-1:0]    wa;
  logic [DataW-1:0] wd;

  logic [CW-1:0]    cm1, cm2;
  logic             tok_go, fin_go;
  logic [DataW:0]   sh;
  logic             ge;
  logic [DataW:0]   diff;
  logic [DataW-1:0] mag_l, mag_r, quo_s;

  assign cm1    = cnt_q - CW'(1);
  assign cm2    = cnt_q - CW'(2);
  assign tok_go = tok_i.valid && tok_i.ready;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || res_o.ready);

  assign tok_i.ready  = (state_q == ST_IDLE);
  assign res_o.valid  = out_valid_q;
  assign res_o.value  = out_value_q;
  assign res_o.status = out_status_q;

  assign sh    = {rem_q, quo_q[DataW-1]};
  assign diff  = sh - {1'b0, dvs_q};
  assign ge    = (sh >= {1'b0, dvs_q});
  assign mag_l = rdb_q[DataW-1] ? (~rdb_q + DataW'(1)) : rdb_q;
  assign mag_r = rda_q[DataW-1] ? (~rda_q + DataW'(1)) : rda_q;
  assign quo_s = neg_q ? (~quo_q + DataW'(1)) : quo_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    act_d        = act_q;
    last_d       = last_q;
    bot_d        = bot_q;
    res_d        = res_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dvs_d        = dvs_q;
    neg_d        = neg_q;
    bit_d        = bit_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    rd_en        = 1'b0;
    we           = 1'b0;
    wa           = cnt_q[AW-1:0];
    wd           = {{(DataW-DigitW){1'b0}}, tok_i.digit};

    unique case (state_q)
      ST_IDLE: begin
        if (tok_go) begin
          act_d   = tok_i.action;
          last_d  = tok_i.last;
          state_d = tok_i.last ? ST_FIN : ST_IDLE;
          if (err_q == ERR_NONE) begin
            case (tok_i.action)
              ACT_PUSH: begin
                if (cnt_q >= CW'(STACK_DEPTH)) begin
                  err_d = ERR_OVERFLOW;
                end else begin
                  we    = 1'b1;
                  cnt_d = cnt_q + CW'(1);
                  if (cnt_q == '0) begin
                    bot_d = wd;
                  end
                end
              end
              ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                if (cnt_q < CW'(2)) begin
                  err_d = ERR_UNDERFLOW;
                end else begin
                  rd_en   = 1'b1;
                  state_d = ST_RD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_RD: begin
        state_d = ST_WB;
        case (act_q)
          ACT_ADD: res_d = rdb_q + rda_q;
          ACT_SUB: res_d = rdb_q - rda_q;
          ACT_MUL: res_d = rdb_q * rda_q;
          default: begin
            if (rda_q == '0) begin
              err_d   = ERR_DIVZERO;
              cnt_d   = cm2;
              state_d = last_q ? ST_FIN : ST_IDLE;
            end else begin
              rem_d   = '0;
              quo_d   = mag_l;
              dvs_d   = mag_r;
              neg_d   = rdb_q[DataW-1] ^ rda_q[DataW-1];
              bit_d   = 5'd31;
              state_d = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        rem_d = ge ? diff[DataW-1:0] : sh[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], ge};
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        we    = 1'b1;
        wa    = cm2[AW-1:0];
        wd    = (act_q == ACT_DIV) ? quo_s : res_q;
        cnt_d = cm1;
        if (cm2 == '0) begin
          bot_d = wd;
        end
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          if (err_q == ERR_NONE && cnt_q == '0) begin
            out_status_d = ERR_UNDERFLOW;
            out_value_d  = '0;
          end else begin
            out_status_d = err_q;
            out_value_d  = (err_q == ERR_NONE) ? $signed(bot_q) : '0;
          end
          cnt_d   = '0;
          err_d   = ERR_NONE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    last_q       <= last_d;
    bot_q        <= bot_d;
    res_q        <= res_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    dvs_q        <= dvs_d;
    neg_q        <= neg_d;
    bit_q        <= bit_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rda_q <= mem_q[cm1[AW-1:0]];
      rdb_q <= mem_q[cm2[AW-1:0]];
    end
  end

  `PSE_ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(STACK_DEPTH), "stack count above depth")
  `PSE_ASSERT_SAME(a_rd_operands, clk_i, rst_ni, state_q == ST_RD, cnt_q >= CW'(2), "operator read without two operands")
  `PSE_ASSERT_NEXT(a_fin_clears, clk_i, rst_ni, fin_go, cnt_q == '0 && err_q == ERR_NONE && out_valid_q, "expression end did not clear the stack")
  `PSE_ASSERT_NEXT(a_err_frozen, clk_i, rst_ni, tok_go && err_q != ERR_NONE, $stable(cnt_q) && $stable(err_q), "token changed the stack after an error")
  `PSE_ASSERT_NEXT(a_div_done, clk_i, rst_ni, state_q == ST_DIV && bit_q == 5'd0, state_q == ST_WB, "divide did not end in write back")

endmodule
